// ===== src/dpad_pkg.sv =====
// Shared types and constants of the DMX phase-angle dimmer.
`timescale 1ns / 1ps

package dpad_pkg;

	// Sizing
	localparam int CHANNELS   = 8;
	localparam int MAX_SLOTS  = 512;
	localparam int LAST_START = MAX_SLOTS - CHANNELS + 1;
	localparam int SLOT_W     = $clog2(MAX_SLOTS + 2);
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Field and register widths
	localparam int BYTE_W    = 8;
	localparam int START_W   = 9;
	localparam int TIMEOUT_W = 16;
	localparam int PHASE_W   = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Register reset values
	localparam logic [START_W-1:0]   START_RESET   = 9'd1;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd8000;
	localparam logic [PHASE_W-1:0]   TOP_RESET     = 8'd240;
	localparam logic [TIMEOUT_W-1:0] LOST_RESET    = 16'd8000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_TOP     = 2'd2;

	// Item kinds
	typedef enum logic [1:0] {
		FUNC_BYTE = 2'd0,
		FUNC_TICK = 2'd1,
		FUNC_SYNC = 2'd2
	} func_t;

	// One input item as it leaves the input register
	typedef struct packed {
		logic                go;
		func_t               func;
		logic [BYTE_W-1:0]   rx_byte;
		logic                framing_error;
	} item_t;

	// Tick result
	typedef struct packed {
		logic [CHANNELS-1:0] lamp_bits;
		logic                signal_lost;
	} result_t;

endpackage

// ===== src/dpad_frame.sv =====
// DMX frame decoder: slot counting, start code check and level capture.
`timescale 1ns / 1ps

module dpad_frame (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  dpad_pkg::item_t                                 item,
	input  logic [dpad_pkg::START_W-1:0]                    start_address,
	output logic [dpad_pkg::CHANNELS-1:0][dpad_pkg::BYTE_W-1:0] levels,
	output logic                                            lost_clear
);

	logic [dpad_pkg::SLOT_W-1:0]  slot_count_q;
	logic                         frame_valid_q;
	logic [dpad_pkg::CHANNELS-1:0][dpad_pkg::BYTE_W-1:0] level_q;

	logic                         is_byte;
	logic                         brk_item;
	logic                         data_item;
	logic [dpad_pkg::START_W-1:0] base;
	logic [dpad_pkg::SLOT_W-1:0]  base_ext;
	logic [dpad_pkg::SLOT_W-1:0]  ch_off;
	logic                         in_range;
	logic                         hit;

	// Item decode
	assign is_byte   = item.go && (item.func == dpad_pkg::FUNC_BYTE);
	assign brk_item  = is_byte && item.framing_error;
	assign data_item = is_byte && !item.framing_error && frame_valid_q;

	// Clamp the start address into the usable slot range
	always_comb begin
		base = start_address;
		if (start_address == '0)
			base = dpad_pkg::START_W'(1);
		else if (start_address > dpad_pkg::START_W'(dpad_pkg::LAST_START))
			base = dpad_pkg::START_W'(dpad_pkg::LAST_START);
	end

	// Slot to channel mapping
	assign base_ext = dpad_pkg::SLOT_W'(base);
	assign ch_off   = slot_count_q - base_ext;
	assign in_range = (slot_count_q >= dpad_pkg::SLOT_W'(1))
		&& (slot_count_q <= dpad_pkg::SLOT_W'(dpad_pkg::MAX_SLOTS));
	assign hit      = data_item && in_range && (slot_count_q >= base_ext)
		&& (ch_off < dpad_pkg::SLOT_W'(dpad_pkg::CHANNELS));

	// A break ends a frame that carried data
	assign lost_clear = brk_item && (slot_count_q > dpad_pkg::SLOT_W'(1));
	assign levels     = level_q;

	// Frame state and captured levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q  <= '0;
			frame_valid_q <= 1'b0;
			level_q       <= '0;
		end else begin
			if (brk_item) begin
				frame_valid_q <= (item.rx_byte == '0);
				slot_count_q  <= (item.rx_byte == '0) ? dpad_pkg::SLOT_W'(1) : '0;
			end else if (data_item) begin
				if (slot_count_q < dpad_pkg::SLOT_W'(dpad_pkg::MAX_SLOTS + 1))
					slot_count_q <= slot_count_q + dpad_pkg::SLOT_W'(1);
			end
			for (int i = 0; i < dpad_pkg::CHANNELS; i++) begin
				if (hit && (ch_off[dpad_pkg::CH_W-1:0] == dpad_pkg::CH_W'(i)))
					level_q[i] <= item.rx_byte;
			end
		end
	end

endmodule

// ===== src/dpad_lamp.sv =====
// Phase counter, signal-lost counter and lamp pattern compare.
`timescale 1ns / 1ps

module dpad_lamp (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  dpad_pkg::item_t                                 item,
	input  logic [dpad_pkg::CHANNELS-1:0][dpad_pkg::BYTE_W-1:0] levels,
	input  logic                                            lost_clear,
	input  logic [dpad_pkg::TIMEOUT_W-1:0]                  lost_timeout,
	input  logic [dpad_pkg::PHASE_W-1:0]                    phase_top,
	output logic                                            tick,
	output dpad_pkg::result_t                               result
);

	logic [dpad_pkg::PHASE_W-1:0]   phase_q;
	logic [dpad_pkg::TIMEOUT_W-1:0] lost_count_q;

	logic                           sync;
	logic                           lost;
	logic [dpad_pkg::PHASE_W-1:0]   phase_inc;
	logic [dpad_pkg::PHASE_W-1:0]   phase_nxt;
	logic [dpad_pkg::PHASE_W:0]     sum [dpad_pkg::CHANNELS];

	assign tick = item.go && (item.func == dpad_pkg::FUNC_TICK);
	assign sync = item.go && (item.func == dpad_pkg::FUNC_SYNC);

	// Next phase with wrap past the top
	assign phase_inc = phase_q + dpad_pkg::PHASE_W'(1);
	assign phase_nxt = (phase_inc > phase_top) ? '0 : phase_inc;
	assign lost      = (lost_count_q >= lost_timeout);

	// Lamp on when phase > 255 - level, i.e. phase + level carries out
	always_comb begin
		for (int i = 0; i < dpad_pkg::CHANNELS; i++) begin
			sum[i] = {1'b0, phase_nxt} + {1'b0, levels[i]};
			result.lamp_bits[i] = !lost && sum[i][dpad_pkg::PHASE_W];
		end
		result.signal_lost = lost;
	end

	// Counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			lost_count_q <= dpad_pkg::LOST_RESET;
		end else begin
			if (sync)
				phase_q <= '0;
			else if (tick)
				phase_q <= phase_nxt;
			if (lost_clear)
				lost_count_q <= '0;
			else if (tick && !lost)
				lost_count_q <= lost_count_q + dpad_pkg::TIMEOUT_W'(1);
		end
	end

endmodule

// ===== src/dmx_phase_angle_dimmer.sv =====
// Top level of the DMX phase-angle dimmer: stream ports, registers, pipeline.
//
//  channel | dir | beat contents
//  s_*     | in  | tdata rx_byte; tuser func[1:0], framing_error[2]
//  m_*     | out | tdata lamp_bits; tuser signal_lost (one beat per tick)
//  cfg_*   | in  | write of start_address / lost_timeout / phase_top
//
// One beat per cycle unless a tick waits: an input register, the compare/count
// logic between them, then the result register.
// Byte and sync beats never wait on the output; a tick waits in the input
// register only while the result register is full and m_tready is low.
// arst_n clears the slot and phase counters, levels and valid flags, sets the
// lost counter to its lost value and loads register resets.
`timescale 1ns / 1ps

module dmx_phase_angle_dimmer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
	input  logic [2:0]                        s_tuser,   // [1:0] func, [2] framing_error
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,   // [7:0] lamp_bits
	output logic [0:0]                        m_tuser,   // [0] signal_lost
	input  logic                              cfg_we,
	input  logic [dpad_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dpad_pkg::CFG_W-1:0]        cfg_data
);

	logic [dpad_pkg::START_W-1:0]   start_address_q;
	logic [dpad_pkg::TIMEOUT_W-1:0] lost_timeout_q;
	logic [dpad_pkg::PHASE_W-1:0]   phase_top_q;

	logic                           valid_s1;
	logic [1:0]                     func_s1;
	logic [dpad_pkg::BYTE_W-1:0]    byte_s1;
	logic                           ferr_s1;

	logic                           out_valid_q;
	dpad_pkg::result_t              out_q;

	dpad_pkg::item_t                item;
	dpad_pkg::result_t              result;
	logic [dpad_pkg::CHANNELS-1:0][dpad_pkg::BYTE_W-1:0] levels;
	logic                           lost_clear;
	logic                           tick;
	logic                           is_tick_s1;
	logic                           advance;
	logic                           s_beat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_address_q <= dpad_pkg::START_RESET;
			lost_timeout_q  <= dpad_pkg::TIMEOUT_RESET;
			phase_top_q     <= dpad_pkg::TOP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dpad_pkg::REG_START_ADDRESS: start_address_q <= cfg_data[dpad_pkg::START_W-1:0];
				dpad_pkg::REG_LOST_TIMEOUT:  lost_timeout_q  <= cfg_data[dpad_pkg::TIMEOUT_W-1:0];
				dpad_pkg::REG_PHASE_TOP:     phase_top_q     <= cfg_data[dpad_pkg::PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage handshake: a tick needs room in the result register
	assign is_tick_s1 = (func_s1 == dpad_pkg::FUNC_TICK);
	assign advance    = valid_s1 && (!is_tick_s1 || !out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || advance;
	assign s_beat     = s_tvalid && s_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_beat) begin
			func_s1 <= s_tuser[1:0];
			ferr_s1 <= s_tuser[2];
			byte_s1 <= s_tdata;
		end
	end

	// Item handed to the work units; unused kind 3 matches no unit
	always_comb begin
		item.go            = advance;
		item.func          = dpad_pkg::func_t'(func_s1);
		item.rx_byte       = byte_s1;
		item.framing_error = ferr_s1;
	end

	dpad_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.start_address(start_address_q),
		.levels       (levels),
		.lost_clear   (lost_clear)
	);

	dpad_lamp u_lamp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.levels       (levels),
		.lost_clear   (lost_clear),
		.lost_timeout (lost_timeout_q),
		.phase_top    (phase_top_q),
		.tick         (tick),
		.result       (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick)
			out_q <= result;
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_q.lamp_bits;
	assign m_tuser[0] = out_q.signal_lost;

	// A processed tick always leaves a result beat behind
	assert property (@(posedge clk) disable iff (!arst_n) tick |=> m_tvalid)
		else $error("tick processed without a result beat");

	// A tick never overwrites a result that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		tick |-> (!out_valid_q || m_tready))
		else $error("result overwritten while stalled");

	// Byte and sync beats do not create results
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !is_tick_s1 && !m_tvalid) |=> !m_tvalid)
		else $error("result beat from a non-tick item");

	// The input side only stalls while the input register is occupied
	assert property (@(posedge clk) disable iff (!arst_n) !s_tready |-> valid_s1)
		else $error("input stalled with an empty input register");

endmodule

// ===== bench/dmx_phase_angle_dimmer_tb.sv =====
// Self-checking bench for the DMX phase-angle dimmer: frame parsing, lamp timing, loss timeout.
`timescale 1ns / 1ps

module dmx_phase_angle_dimmer_tb;
	import dpad_pkg::*;

	localparam logic [1:0] FUNC_UNUSED    = 2'd3;
	localparam int         DRAIN_CYCLES   = 4;     // pipeline is 2 deep, plus margin
	localparam int         WATCHDOG_LIMIT = 2000;  // cycles without any beat or write
	localparam int         SMALL_BUDGET   = 100;
	localparam int         BIG_BUDGET     = 700;

	// One stream beat into the block
	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic        brk;
	} dmx_beat_t;

	// One tick result
	typedef struct {
		logic [CHANNELS-1:0] lamps;
		logic                lost;
	} lamp_state_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic [2:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;
	logic [0:0]           m_tuser;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	dmx_phase_angle_dimmer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // [7:0] rx_byte
		.s_tuser   (s_tuser),    // [1:0] func, [2] framing_error
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // [7:0] lamp_bits
		.m_tuser   (m_tuser),    // [0] signal_lost
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Stimulus and expectation stores
	dmx_beat_t   pending_beats[$];
	lamp_state_t predicted_lamps[$];

	int send_idle_pct = 29;
	int recv_idle_pct = 85;
	int mismatches    = 0;
	int beats_made    = 0;
	int beats_taken   = 0;
	int ticks_checked = 0;
	int settings_used = 1;
	int stall_cycles  = 0;

	// Shadow of the dimmer state and registers
	logic [START_W-1:0]   cfg_start;
	logic [TIMEOUT_W-1:0] cfg_timeout;
	logic [PHASE_W-1:0]   cfg_top;
	logic [SLOT_W-1:0]    slot_n;
	bit                   frame_ok;
	logic [7:0]           level [CHANNELS];
	logic [TIMEOUT_W-1:0] lost_n;
	logic [PHASE_W-1:0]   phase_n;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Dimmer behavior: returns 1 when the beat yields a lamp result
	function automatic bit dimmer_step(input dmx_beat_t b, output lamp_state_t r);
		int  base;
		int  ch;
		bit  gone;
		r.lamps = '0;
		r.lost  = 1'b0;
		case (b.kind)
			FUNC_BYTE: begin
				if (b.brk) begin
					if (slot_n > 1) lost_n = '0;
					frame_ok = (b.data == 8'h00);
					slot_n   = frame_ok ? SLOT_W'(1) : '0;
				end else if (frame_ok) begin
					if (slot_n >= 1 && slot_n <= MAX_SLOTS) begin
						base = (cfg_start == 0) ? 1 : int'(cfg_start);
						if (base > LAST_START) base = LAST_START;
						ch = int'(slot_n) - base;
						if (ch >= 0 && ch < CHANNELS) level[ch] = b.data;
					end
					if (slot_n < MAX_SLOTS + 1) slot_n = slot_n + 1'b1;
				end
				return 1'b0;
			end
			FUNC_SYNC: begin
				phase_n = '0;
				return 1'b0;
			end
			FUNC_TICK: begin
				phase_n = phase_n + 1'b1;
				if (phase_n > cfg_top) phase_n = '0;
				gone = (lost_n >= cfg_timeout);
				if (!gone) begin
					for (int i = 0; i < CHANNELS; i++)
						if (int'(phase_n) > 255 - int'(level[i])) r.lamps[i] = 1'b1;
				end
				if (lost_n < cfg_timeout) lost_n = lost_n + 1'b1;
				r.lost = gone;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0h, want %0h (tick %0d)", what, got, want, ticks_checked);
		mismatches++;
	endtask

	// Driver: offers the next pending beat, predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		dmx_beat_t   nb;
		lamp_state_t res;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				nb.kind = s_tuser[1:0];
				nb.brk  = s_tuser[2];
				nb.data = s_tdata;
				beats_taken++;
				if (dimmer_step(nb, res)) predicted_lamps.push_back(res);
			end
			if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nb = pending_beats.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= nb.data;
				s_tuser  <= {nb.brk, nb.kind};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: compare each result beat with the oldest prediction
	always @(posedge clk) begin
		lamp_state_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_lamps.size() == 0) begin
				report_mismatch("result with nothing pending", int'(m_tdata), 0);
			end else begin
				want = predicted_lamps.pop_front();
				if (m_tdata !== want.lamps) report_mismatch("lamp_bits", int'(m_tdata), int'(want.lamps));
				if (m_tuser[0] !== want.lost)
					report_mismatch("signal_lost", int'(m_tuser[0]), int'(want.lost));
			end
			ticks_checked++;
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no beat for %0d cycles", stall_cycles);
				$display("FAILED: results differ");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic push_beat(logic [1:0] kind, logic [7:0] data, logic brk);
		dmx_beat_t b;
		b.kind = kind;
		b.data = data;
		b.brk  = brk;
		pending_beats.push_back(b);
		if (kind != FUNC_UNUSED) beats_made++;
	endtask

	// Break, len data slots with sparse ticks and noise, then a tick burst
	task automatic push_frame(int len);
		int k;
		if ($urandom_range(99) < 8) push_beat(FUNC_BYTE, 8'($urandom_range(1, 255)), 1'b1);
		else push_beat(FUNC_BYTE, 8'h00, 1'b1);
		for (k = 0; k < len; k++) begin
			if ($urandom_range(99) < 4)
				push_beat(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
			else
				push_beat(FUNC_BYTE, 8'($urandom), 1'b0);
			if ($urandom_range(99) < 10) push_beat(FUNC_TICK, 8'($urandom), 1'($urandom));
			if ($urandom_range(999) < 5) push_beat(FUNC_SYNC, 8'($urandom), 1'($urandom));
		end
		repeat ($urandom_range(0, 40)) push_beat(FUNC_TICK, 8'($urandom), 1'($urandom));
		if ($urandom_range(99) < 15) push_beat(FUNC_SYNC, 8'($urandom), 1'($urandom));
	endtask

	// Random frames fit to the window; past slot 48, one over-long frame then short ones
	task automatic run_random(int budget);
		int eff;
		int goal;
		int len;
		bit full_done;
		eff = (cfg_start == 0) ? 1 : ((cfg_start > LAST_START) ? LAST_START : int'(cfg_start));
		goal = beats_made + budget;
		full_done = (eff + CHANNELS <= 48);
		while (beats_made < goal) begin
			if (!full_done) begin
				len = MAX_SLOTS + $urandom_range(1, 4);
				full_done = 1'b1;
			end else if (eff + CHANNELS > 48) begin
				len = $urandom_range(0, 40);
			end else if ($urandom_range(99) < 70) begin
				len = eff + CHANNELS - 1 + $urandom_range(0, 3);
			end else begin
				len = $urandom_range(0, eff + CHANNELS);
			end
			push_frame(len);
		end
	endtask

	// Wait until the block has nothing left in flight
	task automatic settle();
		while (pending_beats.size() != 0 || s_tvalid || predicted_lamps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic [START_W-1:0] start, logic [TIMEOUT_W-1:0] tmo,
	                          logic [PHASE_W-1:0] top);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_START_ADDRESS;
		cfg_data  <= CFG_W'(start);
		@(posedge clk);
		cfg_index <= REG_LOST_TIMEOUT;
		cfg_data  <= tmo;
		@(posedge clk);
		cfg_index <= REG_PHASE_TOP;
		cfg_data  <= CFG_W'(top);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_start   = start;
		cfg_timeout = tmo;
		cfg_top     = top;
		settings_used++;
	endtask

	// Register plan per random phase
	int plan_start [7] = '{1, 505, 0, 511, 1, 0, 8};
	int plan_tmo   [7] = '{40, 65535, 0, 300, 1, 0, 8000};
	int plan_top   [7] = '{255, 255, 0, 128, 1, 0, 240};
	int plan_big   [7] = '{0, 1, 0, 1, 0, 0, 0};

	initial begin
		// Shadow state matches the reset values
		cfg_start   = START_RESET;
		cfg_timeout = TIMEOUT_RESET;
		cfg_top     = TOP_RESET;
		slot_n      = '0;
		frame_ok    = 1'b0;
		lost_n      = LOST_RESET;
		phase_n     = '0;
		for (int i = 0; i < CHANNELS; i++) level[i] = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: lost at reset, extremes of levels, bad start code, short frames
		push_beat(FUNC_TICK, 8'h00, 1'b0);
		push_beat(FUNC_UNUSED, 8'hFF, 1'b1);
		push_beat(FUNC_BYTE, 8'hAA, 1'b0);      // no frame yet: dropped
		push_beat(FUNC_BYTE, 8'h00, 1'b1);
		push_beat(FUNC_BYTE, 8'hFF, 1'b0);
		push_beat(FUNC_BYTE, 8'h00, 1'b0);
		push_beat(FUNC_BYTE, 8'h80, 1'b0);
		push_beat(FUNC_BYTE, 8'h7F, 1'b0);
		push_beat(FUNC_BYTE, 8'h01, 1'b0);
		push_beat(FUNC_BYTE, 8'hFE, 1'b0);
		push_beat(FUNC_BYTE, 8'hFF, 1'b0);
		push_beat(FUNC_BYTE, 8'h55, 1'b0);
		push_beat(FUNC_BYTE, 8'h33, 1'b0);      // past the channel window
		push_beat(FUNC_BYTE, 8'h00, 1'b1);      // break after long frame clears loss
		push_beat(FUNC_TICK, 8'hFF, 1'b1);
		push_beat(FUNC_TICK, 8'h00, 1'b0);
		push_beat(FUNC_SYNC, 8'h00, 1'b0);
		push_beat(FUNC_TICK, 8'h00, 1'b0);
		push_beat(FUNC_BYTE, 8'hFF, 1'b1);      // bad start code
		push_beat(FUNC_BYTE, 8'h12, 1'b0);
		push_beat(FUNC_BYTE, 8'h00, 1'b1);
		push_beat(FUNC_BYTE, 8'h00, 1'b1);      // frame of one slot: no clear
		push_beat(FUNC_TICK, 8'h00, 1'b0);
		push_beat(FUNC_SYNC, 8'hFF, 1'b1);
		settle();

		// Random phases, each under its own register setting
		for (int p = 0; p < 7; p++) begin
			if (p < 2) begin
				send_idle_pct = 29;
				recv_idle_pct = 85;
			end else if (p < 5) begin
				send_idle_pct = 85;
				recv_idle_pct = 29;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 5)
				write_regs(START_W'($urandom_range(1, 40)), TIMEOUT_W'($urandom_range(2, 500)),
				           PHASE_W'($urandom_range(1, 254)));
			else
				write_regs(START_W'(plan_start[p]), TIMEOUT_W'(plan_tmo[p]),
				           PHASE_W'(plan_top[p]));
			run_random(plan_big[p] ? BIG_BUDGET : SMALL_BUDGET);
			settle();
		end

		if (predicted_lamps.size() != 0)
			report_mismatch("results never delivered", predicted_lamps.size(), 0);

		$display("Run: %0d beats accepted, %0d tick results checked", beats_taken, ticks_checked);
		$display("Register settings exercised: %0d, mismatches: %0d", settings_used, mismatches);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/dpad_pkg.sv
src/dpad_frame.sv
src/dpad_lamp.sv
src/dmx_phase_angle_dimmer.sv
bench/dmx_phase_angle_dimmer_tb.sv
